// ===== sv/lpd_pkg.sv =====
// shared constants and types of the lidar packet decoder
`timescale 1ns / 1ps
package lpd_pkg;

  localparam logic [7:0] START_BYTE = 8'hFA;
  localparam logic [7:0] INDEX_BASE = 8'hA0;
  localparam logic [7:0] INDEX_TOP  = 8'hF9;

  // byte positions inside a 22-byte packet
  localparam logic [4:0] PKT_LAST_POS = 5'd21;
  localparam logic [4:0] SUM_LAST_POS = 5'd19;

  localparam int BUF_BYTES    = 20;
  localparam int NUM_READINGS = 4;

  localparam logic [7:0] COV_CAP = 8'd181;
  localparam logic [7:0] COV_SAT = 8'd180;
  localparam logic [9:0] DEG_WRAP  = 10'd360;
  localparam logic [9:0] DEG_WRAP2 = 10'd720;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_MAX_DIST  = 2'd0;
  localparam logic [1:0] REG_COV_THR   = 2'd1;
  localparam logic [1:0] REG_ANGLE_OFS = 2'd2;

  localparam logic [13:0] MAX_DIST_RST  = 14'd16383;
  localparam logic [7:0]  COV_THR_RST   = 8'd180;
  localparam logic [8:0]  ANGLE_OFS_RST = 9'd90;

  typedef enum logic [1:0] {
    ST_READING  = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_INDEX    = 2'd2
  } lpd_status_t;

  typedef struct packed {
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [15:0] qual;
  } lpd_rdg_t;

  typedef struct packed {
    lpd_status_t               status;
    logic [6:0]                pidx;
    logic [9:0]                speed;
    lpd_rdg_t [NUM_READINGS-1:0] rdg;
  } lpd_pkt_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] covered;
    logic       ready_flag;
  } lpd_emit_stat_t;

endpackage

// ===== sv/lpd_assembler.sv =====
// start-byte hunt, byte shift line, running checksum and packet check
`timescale 1ns / 1ps
module lpd_assembler import lpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [7:0] rx_byte,
  output logic       at_end,
  output logic       pkt_valid,
  output lpd_pkt_t   pkt
);

  logic        in_packet;
  logic [4:0]  byte_count;
  logic [31:0] sum;
  logic [7:0]  shreg [BUF_BYTES];

  logic [16:0] fold;
  logic [15:0] rx_chk;
  logic [7:0]  idx_byte;
  logic [7:0]  idx_off;
  logic [15:0] speed_raw;

  assign at_end    = in_packet && (byte_count == PKT_LAST_POS);
  assign pkt_valid = in_fire && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet  <= 1'b0;
      byte_count <= 5'd0;
      sum        <= 32'd0;
    end else if (in_fire) begin
      if (!in_packet) begin
        if (rx_byte == START_BYTE) begin
          in_packet  <= 1'b1;
          byte_count <= 5'd1;
          sum        <= 32'd0;
        end
      end else begin
        if (at_end) begin
          in_packet  <= 1'b0;
          byte_count <= 5'd0;
        end else begin
          byte_count <= byte_count + 5'd1;
        end
        // odd position holds the high byte of a word
        if (byte_count[0] && byte_count <= SUM_LAST_POS) begin
          sum <= {sum[30:0], 1'b0} + {16'd0, rx_byte, shreg[0]};
        end
      end
    end
  end

  // shreg[k] holds the byte k+1 positions back; at packet end shreg[0] is byte 20
  always_ff @(posedge clk) begin
    if (in_fire) begin
      shreg[0] <= rx_byte;
      for (int k = 1; k < BUF_BYTES; k++) begin
        shreg[k] <= shreg[k-1];
      end
    end
  end

  always_comb begin
    fold      = {2'b00, sum[14:0]} + sum[31:15];
    rx_chk    = {rx_byte, shreg[0]};
    idx_byte  = shreg[19];
    idx_off   = idx_byte - INDEX_BASE;
    speed_raw = {shreg[17], shreg[18]};

    if ({1'b0, fold[14:0]} != rx_chk) begin
      pkt.status = ST_CHECKSUM;
    end else if (idx_byte < INDEX_BASE || idx_byte > INDEX_TOP) begin
      pkt.status = ST_INDEX;
    end else begin
      pkt.status = ST_READING;
    end
    pkt.pidx  = idx_off[6:0];
    pkt.speed = speed_raw[15:6];
    for (int i = 0; i < NUM_READINGS; i++) begin
      pkt.rdg[i].lo   = shreg[16-4*i];
      pkt.rdg[i].hi   = shreg[15-4*i];
      pkt.rdg[i].qual = {shreg[13-4*i], shreg[14-4*i]};
    end
  end

endmodule

// ===== sv/lpd_emitter.sv =====
// packet record, per-reading decode, coverage and bad counters, output register
`timescale 1ns / 1ps
module lpd_emitter import lpd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           pkt_valid,
  input  lpd_pkt_t       pkt,
  input  logic [13:0]    max_distance,
  input  logic [7:0]     coverage_threshold,
  input  logic [8:0]     angle_offset,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [1:0]     status,
  output logic [6:0]     packet_index,
  output logic [8:0]     degree,
  output logic [13:0]    distance,
  output logic           invalid,
  output logic           warning,
  output logic [15:0]    quality,
  output logic           in_range,
  output logic [9:0]     speed_rpm,
  output logic           coverage_ready,
  output logic [15:0]    bad_count,
  output logic           last,
  output lpd_emit_stat_t stat
);

  logic        busy;
  logic [1:0]  sel;
  lpd_pkt_t    rec;
  logic [7:0]  covered;
  logic        ready_flag;
  logic [15:0] bad_readings;

  logic        emit;
  lpd_rdg_t    cur;
  logic        is_err;
  logic        inv;
  logic        rd_ok;
  logic        rd_bad;
  logic [13:0] rd_dist;
  logic        inr;
  logic [9:0]  deg_sum;
  logic [9:0]  deg_wrap;
  logic        last_next;
  logic [7:0]  covered_next;
  logic        ready_flag_next;
  logic [15:0] bad_readings_next;

  assign emit = busy && (!out_valid || out_ready);
  assign stat = '{busy: busy, covered: covered, ready_flag: ready_flag};

  always_comb begin
    cur       = rec.rdg[sel];
    is_err    = (rec.status != ST_READING);
    inv       = cur.hi[7];
    rd_ok     = !is_err && !inv;
    rd_bad    = !is_err && inv;
    rd_dist   = inv ? 14'd0 : {cur.hi[5:0], cur.lo};
    inr       = !inv && (rd_dist != 14'd0) && (rd_dist < max_distance);
    last_next = is_err || (sel == 2'(NUM_READINGS - 1));

    deg_sum = {1'b0, rec.pidx, 2'b00} + {1'b0, angle_offset} + {8'd0, sel};
    if (deg_sum >= DEG_WRAP2) begin
      deg_wrap = deg_sum - DEG_WRAP2;
    end else if (deg_sum >= DEG_WRAP) begin
      deg_wrap = deg_sum - DEG_WRAP;
    end else begin
      deg_wrap = deg_sum;
    end

    covered_next      = covered;
    ready_flag_next   = ready_flag;
    bad_readings_next = bad_readings;
    if (rd_ok) begin
      covered_next    = (covered < COV_CAP) ? covered + 8'd1 : COV_SAT;
      ready_flag_next = ready_flag || (covered_next > coverage_threshold);
    end
    if (rd_bad) begin
      bad_readings_next = bad_readings + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      sel          <= 2'd0;
      covered      <= 8'd0;
      ready_flag   <= 1'b0;
      bad_readings <= 16'd0;
      out_valid    <= 1'b0;
    end else begin
      if (pkt_valid) begin
        busy <= 1'b1;
        sel  <= 2'd0;
      end else if (emit) begin
        sel <= sel + 2'd1;
        if (last_next) begin
          busy <= 1'b0;
        end
      end
      if (emit) begin
        covered      <= covered_next;
        ready_flag   <= ready_flag_next;
        bad_readings <= bad_readings_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_valid) begin
      rec <= pkt;
    end
    if (emit) begin
      coverage_ready <= ready_flag_next;
      bad_count      <= bad_readings_next;
      last           <= last_next;
      if (is_err) begin
        status       <= rec.status;
        packet_index <= 7'd0;
        degree       <= 9'd0;
        distance     <= 14'd0;
        invalid      <= 1'b0;
        warning      <= 1'b0;
        quality      <= 16'd0;
        in_range     <= 1'b0;
        speed_rpm    <= 10'd0;
      end else begin
        status       <= ST_READING;
        packet_index <= rec.pidx;
        degree       <= deg_wrap[8:0];
        distance     <= rd_dist;
        invalid      <= inv;
        warning      <= cur.hi[6];
        quality      <= cur.qual;
        in_range     <= inr;
        speed_rpm    <= rec.speed;
      end
    end
  end

endmodule

// ===== sv/lidar_packet_decoder.sv =====
// lidar packet decoder top level: register port, assembler, result emitter
// one byte accepted per cycle while in_ready is high; a packet-ending byte is stored in the
// packet record, then its first result is registered out; the other readings follow one per
// cycle when not stalled; a good packet gives four results, a bad one a single error result
// in_ready drops only when a packet ends while the previous packet's results are still queued
// synchronous reset: hunting for the start byte, counters and flag cleared, registers to defaults
`timescale 1ns / 1ps
module lidar_packet_decoder import lpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [6:0]  packet_index,
  output logic [8:0]  degree,
  output logic [13:0] distance,
  output logic        invalid,
  output logic        warning,
  output logic [15:0] quality,
  output logic        in_range,
  output logic [9:0]  speed_rpm,
  output logic        coverage_ready,
  output logic [15:0] bad_count,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [13:0] max_distance;
  logic [7:0]  coverage_threshold;
  logic [8:0]  angle_offset;

  logic           cfg_write;
  logic           in_fire;
  logic           at_end;
  logic           pkt_valid;
  lpd_pkt_t       pkt;
  lpd_emit_stat_t stat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_distance       <= MAX_DIST_RST;
      coverage_threshold <= COV_THR_RST;
      angle_offset       <= ANGLE_OFS_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_MAX_DIST:  max_distance       <= pwdata[13:0];
        REG_COV_THR:   coverage_threshold <= pwdata[7:0];
        REG_ANGLE_OFS: angle_offset       <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_DIST:  prdata = {18'd0, max_distance};
      REG_COV_THR:   prdata = {24'd0, coverage_threshold};
      REG_ANGLE_OFS: prdata = {23'd0, angle_offset};
      default:       prdata = 32'd0;
    endcase
  end

  // hold off a packet end only while the emitter still owns a record
  assign in_ready = !(at_end && stat.busy);
  assign in_fire  = in_valid && in_ready;

  lpd_assembler u_asm (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .rx_byte   (rx_byte),
    .at_end    (at_end),
    .pkt_valid (pkt_valid),
    .pkt       (pkt)
  );

  lpd_emitter u_emit (
    .clk                (clk),
    .rst                (rst),
    .pkt_valid          (pkt_valid),
    .pkt                (pkt),
    .max_distance       (max_distance),
    .coverage_threshold (coverage_threshold),
    .angle_offset       (angle_offset),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .status             (status),
    .packet_index       (packet_index),
    .degree             (degree),
    .distance           (distance),
    .invalid            (invalid),
    .warning            (warning),
    .quality            (quality),
    .in_range           (in_range),
    .speed_rpm          (speed_rpm),
    .coverage_ready     (coverage_ready),
    .bad_count          (bad_count),
    .last               (last),
    .stat               (stat)
  );

  a_pkt_free: assert property (@(posedge clk) disable iff (rst)
    pkt_valid |-> !stat.busy)
    else $error("packet record overwritten while results pending");

  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    stat.ready_flag |=> stat.ready_flag)
    else $error("coverage ready flag dropped");

  a_cov_cap: assert property (@(posedge clk) disable iff (rst)
    stat.covered <= COV_CAP)
    else $error("coverage count above cap");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (stat.busy && out_valid && !out_ready) |=> $stable(stat.covered))
    else $error("coverage count moved while output stalled");

endmodule
